// File: hw/rtl/kkm_pkg.sv
// Package for the keyboard matrix unit: types, constants and the keycode decode table.
`default_nettype none
package kkm_pkg;

  localparam int unsigned NumRowsDefault = 11;
  localparam int unsigned RowW           = 4;
  localparam int unsigned ColW           = 3;
  localparam int unsigned CodeW          = 8;
  localparam int unsigned DataW          = 8;

  localparam logic [DataW-1:0] RowIdle = 8'hFF;

  // Unmapped keycodes land on this position.
  localparam logic [RowW-1:0] DefaultRow = 4'd2;
  localparam logic [ColW-1:0] DefaultCol = 3'd5;

  typedef enum logic {
    REQ_KEY  = 1'b0,
    REQ_READ = 1'b1
  } kkm_req_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } kkm_pos_t;

  // Write request from the front end to the matrix storage.
  typedef struct packed {
    logic            en;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            pressed;
  } kkm_wr_t;

  function automatic kkm_pos_t kkm_pos(input logic [RowW-1:0] r, input logic [ColW-1:0] c);
    kkm_pos_t p;
    p.row = r;
    p.col = c;
    return p;
  endfunction

  // Host keycode to matrix position.
  function automatic kkm_pos_t kkm_decode(input logic [CodeW-1:0] code);
    kkm_pos_t p;
    case (code)
      8'd9:    p = kkm_pos(4'd7, 3'd2);
      8'd10:   p = kkm_pos(4'd0, 3'd1);
      8'd11:   p = kkm_pos(4'd0, 3'd2);
      8'd12:   p = kkm_pos(4'd0, 3'd3);
      8'd13:   p = kkm_pos(4'd0, 3'd4);
      8'd14:   p = kkm_pos(4'd0, 3'd5);
      8'd15:   p = kkm_pos(4'd0, 3'd6);
      8'd16:   p = kkm_pos(4'd0, 3'd7);
      8'd17:   p = kkm_pos(4'd1, 3'd0);
      8'd18:   p = kkm_pos(4'd1, 3'd1);
      8'd19:   p = kkm_pos(4'd0, 3'd0);
      8'd20:   p = kkm_pos(4'd1, 3'd2);
      8'd21:   p = kkm_pos(4'd1, 3'd3);
      8'd22:   p = kkm_pos(4'd7, 3'd5);
      8'd23:   p = kkm_pos(4'd7, 3'd3);
      8'd24:   p = kkm_pos(4'd4, 3'd6);
      8'd25:   p = kkm_pos(4'd5, 3'd4);
      8'd26:   p = kkm_pos(4'd3, 3'd2);
      8'd27:   p = kkm_pos(4'd4, 3'd7);
      8'd28:   p = kkm_pos(4'd5, 3'd1);
      8'd29:   p = kkm_pos(4'd5, 3'd6);
      8'd30:   p = kkm_pos(4'd5, 3'd2);
      8'd31:   p = kkm_pos(4'd3, 3'd6);
      8'd32:   p = kkm_pos(4'd4, 3'd4);
      8'd33:   p = kkm_pos(4'd4, 3'd5);
      8'd34:   p = kkm_pos(4'd1, 3'd5);
      8'd35:   p = kkm_pos(4'd1, 3'd6);
      8'd36:   p = kkm_pos(4'd7, 3'd7);
      8'd37:   p = kkm_pos(4'd6, 3'd2);
      8'd38:   p = kkm_pos(4'd2, 3'd6);
      8'd39:   p = kkm_pos(4'd5, 3'd0);
      8'd40:   p = kkm_pos(4'd3, 3'd1);
      8'd41:   p = kkm_pos(4'd3, 3'd3);
      8'd42:   p = kkm_pos(4'd3, 3'd4);
      8'd43:   p = kkm_pos(4'd3, 3'd5);
      8'd44:   p = kkm_pos(4'd3, 3'd7);
      8'd45:   p = kkm_pos(4'd4, 3'd0);
      8'd46:   p = kkm_pos(4'd4, 3'd1);
      8'd47:   p = kkm_pos(4'd1, 3'd7);
      8'd48:   p = kkm_pos(4'd2, 3'd0);
      8'd49:   p = kkm_pos(4'd2, 3'd1);
      8'd50:   p = kkm_pos(4'd6, 3'd0);
      8'd52:   p = kkm_pos(4'd5, 3'd7);
      8'd53:   p = kkm_pos(4'd5, 3'd5);
      8'd54:   p = kkm_pos(4'd3, 3'd0);
      8'd55:   p = kkm_pos(4'd5, 3'd3);
      8'd56:   p = kkm_pos(4'd2, 3'd7);
      8'd57:   p = kkm_pos(4'd4, 3'd3);
      8'd58:   p = kkm_pos(4'd4, 3'd2);
      8'd59:   p = kkm_pos(4'd2, 3'd2);
      8'd60:   p = kkm_pos(4'd2, 3'd3);
      8'd61:   p = kkm_pos(4'd2, 3'd4);
      8'd62:   p = kkm_pos(4'd6, 3'd0);
      8'd63:   p = kkm_pos(4'd9, 3'd0);
      8'd64:   p = kkm_pos(4'd6, 3'd2);
      8'd65:   p = kkm_pos(4'd8, 3'd0);
      8'd66:   p = kkm_pos(4'd6, 3'd3);
      8'd67:   p = kkm_pos(4'd6, 3'd5);
      8'd68:   p = kkm_pos(4'd6, 3'd6);
      8'd69:   p = kkm_pos(4'd6, 3'd7);
      8'd70:   p = kkm_pos(4'd7, 3'd0);
      8'd71:   p = kkm_pos(4'd7, 3'd1);
      8'd72:   p = kkm_pos(4'd8, 3'd1);
      8'd73:   p = kkm_pos(4'd8, 3'd2);
      8'd74:   p = kkm_pos(4'd8, 3'd3);
      8'd75:   p = kkm_pos(4'd7, 3'd6);
      8'd76:   p = kkm_pos(4'd7, 3'd4);
      8'd79:   p = kkm_pos(4'd10, 3'd2);
      8'd80:   p = kkm_pos(4'd10, 3'd3);
      8'd81:   p = kkm_pos(4'd10, 3'd4);
      8'd82:   p = kkm_pos(4'd10, 3'd5);
      8'd83:   p = kkm_pos(4'd7, 3'd7);
      8'd84:   p = kkm_pos(4'd10, 3'd0);
      8'd85:   p = kkm_pos(4'd10, 3'd1);
      8'd86:   p = kkm_pos(4'd9, 3'd1);
      8'd87:   p = kkm_pos(4'd9, 3'd4);
      8'd88:   p = kkm_pos(4'd9, 3'd5);
      8'd89:   p = kkm_pos(4'd9, 3'd6);
      8'd90:   p = kkm_pos(4'd9, 3'd3);
      8'd91:   p = kkm_pos(4'd10, 3'd7);
      8'd106:  p = kkm_pos(4'd9, 3'd2);
      8'd108:  p = kkm_pos(4'd6, 3'd4);
      8'd111:  p = kkm_pos(4'd8, 3'd5);
      8'd113:  p = kkm_pos(4'd8, 3'd4);
      8'd114:  p = kkm_pos(4'd8, 3'd7);
      8'd115:  p = kkm_pos(4'd8, 3'd6);
      default: p = kkm_pos(DefaultRow, DefaultCol);
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/keycode_to_key_matrix_unit.sv
// Top level of the keyboard matrix unit: request register, decode and result register.
// A row read's result passes from the request register to the result register.
// One request per cycle while the result register drains: a key event always retires from the
// request register, and a row read retires once the result register has room to take it.
// Key events produce no result. Reset (rst_n low, synchronous) sets every matrix row to
// all ones (no key pressed) and empties the request and result registers.
`default_nettype none
module keycode_to_key_matrix_unit #(
  parameter int unsigned NUM_ROWS = kkm_pkg::NumRowsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_req_type,
  input  wire logic [kkm_pkg::CodeW-1:0] in_key_code,
  input  wire logic                      in_key_pressed,
  input  wire logic [kkm_pkg::RowW-1:0]  in_row_select,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [kkm_pkg::DataW-1:0] out_row_data
);
  import kkm_pkg::*;

  // Request register. It holds one request while it is decoded and applied.
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  kkm_req_t         s1_req_type_r;
  logic [CodeW-1:0] s1_key_code_r;
  logic             s1_key_pressed_r;
  logic [RowW-1:0]  s1_row_select_r;

  // Result register. It parts the request side from a stalled consumer.
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [DataW-1:0] out_row_data_r;

  logic             in_fire;
  logic             s1_is_read;
  logic             s1_done;
  logic             out_free;
  kkm_pos_t         key_pos;
  kkm_wr_t          mat_wr;
  logic [DataW-1:0] mat_rd_data;

  assign in_fire    = in_valid && in_ready;
  assign s1_is_read = s1_req_type_r == REQ_READ;
  assign out_free   = !out_valid_r || out_ready;

  // A key event always retires from the request register. A row read needs room in the result
  // register, so only a read behind a stalled result holds the request register.
  assign s1_done  = s1_valid_r && (!s1_is_read || out_free);
  assign in_ready = !s1_valid_r || s1_done;

  // Decode the keycode to its matrix position; unmapped codes fall to the default key.
  assign key_pos = kkm_decode(s1_key_code_r);

  always_comb begin
    mat_wr.en      = s1_valid_r && !s1_is_read;
    mat_wr.row     = key_pos.row;
    mat_wr.col     = key_pos.col;
    mat_wr.pressed = s1_key_pressed_r;
  end

  // A read sees every key event accepted ahead of it, because events update the
  // matrix at the end of their own cycle in the request register.
  kkm_matrix #(
    .NUM_ROWS (NUM_ROWS)
  ) u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mat_wr),
    .rd_row  (s1_row_select_r),
    .rd_data (mat_rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_done && s1_is_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_type_r    <= kkm_req_t'(in_req_type);
      s1_key_code_r    <= in_key_code;
      s1_key_pressed_r <= in_key_pressed;
      s1_row_select_r  <= in_row_select;
    end
    if (s1_done && s1_is_read) begin
      out_row_data_r <= mat_rd_data;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row_data = out_row_data_r;

  // A key event never raises a result on its own.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_is_read && (!out_valid_r || out_ready)) |=> !out_valid_r)
    else $error("key event produced a result");

  // A read of a row past the matrix returns all ones.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_done && s1_is_read && (int'(s1_row_select_r) >= NUM_ROWS))
      |=> (out_valid_r && (out_row_data_r == RowIdle)))
    else $error("out-of-range row read not all ones");

  // The request register only stalls on a read that waits for the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_is_read && out_valid_r && !out_ready))
    else $error("request side stalled without cause");

  // A row read that retires always leaves a result behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_done && s1_is_read) |=> out_valid_r)
    else $error("row read lost its result");

endmodule
`default_nettype wire

// File: hw/rtl/kkm_matrix.sv
// Key matrix storage: active-low row registers with one bit write and one row read port.
`default_nettype none
module kkm_matrix #(
  parameter int unsigned NUM_ROWS = kkm_pkg::NumRowsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire kkm_pkg::kkm_wr_t          wr,
  input  wire logic [kkm_pkg::RowW-1:0]  rd_row,
  output logic      [kkm_pkg::DataW-1:0] rd_data
);
  import kkm_pkg::*;

  localparam int unsigned IdxW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  logic [DataW-1:0] rows_r [NUM_ROWS];
  logic             wr_hit;
  logic             rd_hit;

  assign wr_hit = wr.en && (int'(wr.row) < NUM_ROWS);
  assign rd_hit = int'(rd_row) < NUM_ROWS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        rows_r[i] <= RowIdle;
      end
    end else if (wr_hit) begin
      // Active low: a press clears the bit, a release sets it.
      rows_r[wr.row[IdxW-1:0]][wr.col] <= ~wr.pressed;
    end
  end

  assign rd_data = rd_hit ? rows_r[rd_row[IdxW-1:0]] : RowIdle;

endmodule
`default_nettype wire

// File: test/keycode_to_key_matrix_unit_test.sv
// Self-checking testbench for the keyboard matrix unit: directed and random requests.
`timescale 1ns / 100ps
module keycode_to_key_matrix_unit_test;
  import kkm_pkg::*;

  localparam int unsigned NUM_ROWS           = NumRowsDefault;
  localparam int unsigned MAP_LEN            = 86;
  localparam int unsigned RANDOM_REQUESTS    = 1350;
  localparam int unsigned FULL_RATE_REQUESTS = 200;
  localparam int unsigned BURST_REQUESTS     = 24;
  localparam int unsigned HOLD_OFF_CYCLES    = 60;
  localparam int unsigned DRAIN_LIMIT        = 10000;
  localparam int unsigned TAIL_CYCLES        = 8;
  localparam int unsigned TIMEOUT_NS         = 1000000;

  // Host keycode to matrix position, packed as {code, row, column}. Codes that are
  // missing here land on the default position from the package.
  localparam logic [0:MAP_LEN-1][14:0] KEY_MAP = {
    {8'd9, 4'd7, 3'd2},    {8'd10, 4'd0, 3'd1},   {8'd11, 4'd0, 3'd2},   {8'd12, 4'd0, 3'd3},
    {8'd13, 4'd0, 3'd4},   {8'd14, 4'd0, 3'd5},   {8'd15, 4'd0, 3'd6},   {8'd16, 4'd0, 3'd7},
    {8'd17, 4'd1, 3'd0},   {8'd18, 4'd1, 3'd1},   {8'd19, 4'd0, 3'd0},   {8'd20, 4'd1, 3'd2},
    {8'd21, 4'd1, 3'd3},   {8'd22, 4'd7, 3'd5},   {8'd23, 4'd7, 3'd3},   {8'd24, 4'd4, 3'd6},
    {8'd25, 4'd5, 3'd4},   {8'd26, 4'd3, 3'd2},   {8'd27, 4'd4, 3'd7},   {8'd28, 4'd5, 3'd1},
    {8'd29, 4'd5, 3'd6},   {8'd30, 4'd5, 3'd2},   {8'd31, 4'd3, 3'd6},   {8'd32, 4'd4, 3'd4},
    {8'd33, 4'd4, 3'd5},   {8'd34, 4'd1, 3'd5},   {8'd35, 4'd1, 3'd6},   {8'd36, 4'd7, 3'd7},
    {8'd37, 4'd6, 3'd2},   {8'd38, 4'd2, 3'd6},   {8'd39, 4'd5, 3'd0},   {8'd40, 4'd3, 3'd1},
    {8'd41, 4'd3, 3'd3},   {8'd42, 4'd3, 3'd4},   {8'd43, 4'd3, 3'd5},   {8'd44, 4'd3, 3'd7},
    {8'd45, 4'd4, 3'd0},   {8'd46, 4'd4, 3'd1},   {8'd47, 4'd1, 3'd7},   {8'd48, 4'd2, 3'd0},
    {8'd49, 4'd2, 3'd1},   {8'd50, 4'd6, 3'd0},   {8'd52, 4'd5, 3'd7},   {8'd53, 4'd5, 3'd5},
    {8'd54, 4'd3, 3'd0},   {8'd55, 4'd5, 3'd3},   {8'd56, 4'd2, 3'd7},   {8'd57, 4'd4, 3'd3},
    {8'd58, 4'd4, 3'd2},   {8'd59, 4'd2, 3'd2},   {8'd60, 4'd2, 3'd3},   {8'd61, 4'd2, 3'd4},
    {8'd62, 4'd6, 3'd0},   {8'd63, 4'd9, 3'd0},   {8'd64, 4'd6, 3'd2},   {8'd65, 4'd8, 3'd0},
    {8'd66, 4'd6, 3'd3},   {8'd67, 4'd6, 3'd5},   {8'd68, 4'd6, 3'd6},   {8'd69, 4'd6, 3'd7},
    {8'd70, 4'd7, 3'd0},   {8'd71, 4'd7, 3'd1},   {8'd72, 4'd8, 3'd1},   {8'd73, 4'd8, 3'd2},
    {8'd74, 4'd8, 3'd3},   {8'd75, 4'd7, 3'd6},   {8'd76, 4'd7, 3'd4},   {8'd79, 4'd10, 3'd2},
    {8'd80, 4'd10, 3'd3},  {8'd81, 4'd10, 3'd4},  {8'd82, 4'd10, 3'd5},  {8'd83, 4'd7, 3'd7},
    {8'd84, 4'd10, 3'd0},  {8'd85, 4'd10, 3'd1},  {8'd86, 4'd9, 3'd1},   {8'd87, 4'd9, 3'd4},
    {8'd88, 4'd9, 3'd5},   {8'd89, 4'd9, 3'd6},   {8'd90, 4'd9, 3'd3},   {8'd91, 4'd10, 3'd7},
    {8'd106, 4'd9, 3'd2},  {8'd108, 4'd6, 3'd4},  {8'd111, 4'd8, 3'd5},  {8'd113, 4'd8, 3'd4},
    {8'd114, 4'd8, 3'd7},  {8'd115, 4'd8, 3'd6}
  };

  // Every input starts at a known value; reset is held low from time zero.
  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  kkm_req_t         in_req_type    = REQ_KEY;
  logic [CodeW-1:0] in_key_code    = '0;
  logic             in_key_pressed = 1'b0;
  logic [RowW-1:0]  in_row_select  = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [DataW-1:0] out_row_data;

  // Predicted matrix contents and the row bytes that row reads still owe us.
  logic [DataW-1:0] key_rows [NUM_ROWS];
  logic [DataW-1:0] expected_rows [$];
  int unsigned      errors           = 0;
  bit               source_idles     = 1'b0;
  bit               sink_idles       = 1'b0;
  int unsigned      hold_off_request = 0;

  keycode_to_key_matrix_unit #(
    .NUM_ROWS(NUM_ROWS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_key_code   (in_key_code),
    .in_key_pressed(in_key_pressed),
    .in_row_select (in_row_select),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_data  (out_row_data)
  );

  always #1 clk = ~clk;

  // Scan the keycode table; a code that is not listed falls on the default position.
  function automatic void locate_key(input logic [CodeW-1:0] code, output logic [RowW-1:0] row,
                                     output logic [ColW-1:0] col);
    row = DefaultRow;
    col = DefaultCol;
    for (int unsigned i = 0; i < MAP_LEN; i++) begin
      if (KEY_MAP[i][14:7] == code) begin
        row = KEY_MAP[i][6:3];
        col = KEY_MAP[i][2:0];
      end
    end
  endfunction

  // Apply one accepted request to the predicted matrix. A key event clears the bit on a
  // press and sets it on a release; a row read owes one byte, all ones past the last row.
  function automatic void apply_request(input kkm_req_t kind, input logic [CodeW-1:0] code,
                                        input logic down, input logic [RowW-1:0] sel);
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    if (kind == REQ_KEY) begin
      locate_key(code, row, col);
      key_rows[row][col] = ~down;
    end else begin
      expected_rows.push_back((sel < NUM_ROWS) ? key_rows[sel] : RowIdle);
    end
  endfunction

  // Compare one accepted result with the oldest outstanding row read.
  function automatic void check_row_data(input logic [DataW-1:0] got);
    logic [DataW-1:0] want;
    if (expected_rows.size() == 0) begin
      $display("%0t: row_data expected none, actual 0x%02h", $time, got);
      errors++;
    end else begin
      want = expected_rows.pop_front();
      if (got !== want) begin
        $display("%0t: row_data expected 0x%02h, actual 0x%02h", $time, want, got);
        errors++;
      end
    end
  endfunction

  // Both channels are observed in one process at the clock edge, so the prediction for a
  // request is always queued before the result it causes can be checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_request(in_req_type, in_key_code, in_key_pressed, in_row_select);
      end
      if (out_valid && out_ready) begin
        check_row_data(out_row_data);
      end
    end
  end

  // Result side ready. A long hold-off asked for by a test is counted down here; otherwise
  // the sink stalls in bursts of random length while sink idling is enabled.
  initial begin : sink_ready
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (sink_idles && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until accepted. While source idling is enabled a random
  // gap may follow. When no gap follows, valid stays high into the next request, so each
  // input sees a single assignment per edge.
  task automatic send_request(input kkm_req_t kind, input logic [CodeW-1:0] code,
                              input logic down, input logic [RowW-1:0] sel);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_key_code    <= code;
    in_key_pressed <= down;
    in_row_select  <= sel;
    do @(posedge clk); while (!in_ready);
    if (source_idles && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering requests until every outstanding row read has returned. The first edge
  // lets the monitor record a request accepted at the edge this task was entered on. The
  // wait is bounded; anything left over is reported at the end of the run.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int unsigned i = 0; i < DRAIN_LIMIT && expected_rows.size() != 0; i++) begin
      @(posedge clk);
    end
  endtask

  // Random request. Most key events use listed codes so the matrix fills up; the rest use
  // any code. Unused fields carry random junk, which the block must ignore.
  task automatic send_random_request();
    kkm_req_t         kind;
    logic [CodeW-1:0] code;
    logic [RowW-1:0]  sel;
    kind = ($urandom_range(0, 99) < 45) ? REQ_READ : REQ_KEY;
    if (kind == REQ_KEY && $urandom_range(0, 99) < 85) begin
      code = KEY_MAP[$urandom_range(0, MAP_LEN - 1)][14:7];
    end else begin
      code = CodeW'($urandom_range(0, 255));
    end
    if (kind == REQ_READ && $urandom_range(0, 99) < 85) begin
      sel = RowW'($urandom_range(0, NUM_ROWS - 1));
    end else begin
      sel = RowW'($urandom_range(0, 15));
    end
    send_request(kind, code, 1'($urandom_range(0, 1)), sel);
  endtask

  // Straight after reset every row, including rows past the last, reads all ones.
  task automatic test_reset_rows();
    send_request(REQ_READ, 8'h00, 1'b0, 4'd0);
    send_request(REQ_READ, 8'hFF, 1'b1, 4'd10);
    send_request(REQ_READ, 8'h00, 1'b1, 4'd11);
    send_request(REQ_READ, 8'hFF, 1'b0, 4'd15);
  endtask

  // Codes 0 and 255 are not in the table and both act on the default position.
  task automatic test_unmapped_codes();
    send_request(REQ_KEY, 8'h00, 1'b1, 4'd15);
    send_request(REQ_READ, 8'hFF, 1'b0, DefaultRow);
    send_request(REQ_KEY, 8'hFF, 1'b0, 4'd0);
    send_request(REQ_READ, 8'h00, 1'b1, DefaultRow);
  endtask

  // The first listed code and code 106, pressed together and released.
  task automatic test_table_ends();
    send_request(REQ_KEY, 8'd9, 1'b1, 4'd0);
    send_request(REQ_KEY, 8'd106, 1'b1, 4'd15);
    send_request(REQ_READ, 8'hFF, 1'b1, 4'd7);
    send_request(REQ_READ, 8'hFF, 1'b1, 4'd9);
    send_request(REQ_KEY, 8'd9, 1'b0, 4'd7);
    send_request(REQ_KEY, 8'd106, 1'b0, 4'd9);
    send_request(REQ_READ, 8'h00, 1'b0, 4'd9);
  endtask

  // Both shift codes share one position: the release of one after the press of the other
  // leaves the key up, since the last event on a position wins.
  task automatic test_shared_positions();
    send_request(REQ_KEY, 8'd50, 1'b1, 4'd0);
    send_request(REQ_KEY, 8'd62, 1'b1, 4'd0);
    send_request(REQ_KEY, 8'd50, 1'b0, 4'd0);
    send_request(REQ_READ, 8'd62, 1'b1, 4'd6);
  endtask

  // A key on the last row must not leak into the rows past it.
  task automatic test_last_row();
    send_request(REQ_KEY, 8'd91, 1'b1, 4'd11);
    send_request(REQ_READ, 8'd91, 1'b1, 4'd10);
    send_request(REQ_READ, 8'd91, 1'b1, 4'd11);
  endtask

  // The sink holds off for a long stretch while row reads keep coming, so the result
  // register fills and the block must stall its input without losing a request.
  task automatic test_result_backpressure();
    source_idles = 1'b0;
    sink_idles = 1'b0;
    hold_off_request = HOLD_OFF_CYCLES;
    for (int unsigned i = 0; i < BURST_REQUESTS; i++) begin
      send_request(REQ_READ, CodeW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   RowW'($urandom_range(0, 15)));
    end
    wait_for_results();
  endtask

  // Mixed random traffic. Idling on both sides comes and goes in stretches of a hundred
  // requests, and every two hundred requests the sender pauses until the sink has caught up.
  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      source_idles = ((i / 100) % 3) != 2;
      sink_idles = ((i / 100) % 4) != 3;
      if (i % 200 == 199) begin
        wait_for_results();
      end
      send_random_request();
    end
  endtask

  // Back-to-back requests with both sides always ready.
  task automatic test_full_rate(input int unsigned count);
    source_idles = 1'b0;
    sink_idles = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      send_random_request();
    end
  endtask

  initial begin
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      key_rows[r] = RowIdle;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_rows();
    test_unmapped_codes();
    test_table_ends();
    test_shared_positions();
    test_last_row();
    wait_for_results();
    test_result_backpressure();
    test_random_traffic(RANDOM_REQUESTS);
    test_full_rate(FULL_RATE_REQUESTS);

    // Let the last results drain, then let the block idle for TAIL_CYCLES to show anything
    // it should not have sent.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rows.size() != 0) begin
      $display("%0t: row_data expected %0d more results, actual none", $time,
               expected_rows.size());
      errors++;
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
